/* sv/key_debounce_with_autorepeat_defines.svh */
// Assertion macros shared by the key debounce block.
// Depends on signals named clk and arst_n in the module that uses them.
`ifndef KEY_DEBOUNCE_WITH_AUTOREPEAT_DEFINES_SVH
`define KEY_DEBOUNCE_WITH_AUTOREPEAT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define KDB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("key debounce: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define KDB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("key debounce: next-cycle check failed");

`endif

/* sv/kdb_pkg.sv */
// Types and constants of the key debounce block.
// No dependencies; used by kdb_decode and key_debounce_with_autorepeat.
package kdb_pkg;

	localparam int TIME_W = 63;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// Key classes as they appear on the result channel.
	localparam logic [3:0] CLS_PUTAWAY    = 4'd0;
	localparam logic [3:0] CLS_SYNC       = 4'd1;
	localparam logic [3:0] CLS_FRONTLIGHT = 4'd2;
	localparam logic [3:0] CLS_ENTER      = 4'd3;
	localparam logic [3:0] CLS_BACK       = 4'd4;
	localparam logic [3:0] CLS_UP         = 4'd5;
	localparam logic [3:0] CLS_DOWN       = 4'd6;
	localparam logic [3:0] CLS_LEFT       = 4'd7;
	localparam logic [3:0] CLS_RIGHT      = 4'd8;
	localparam logic [3:0] CLS_CHAR       = 4'd9;

	// Character codes.
	localparam logic [7:0] CP_ENYE_LOWER = 8'hF1;
	localparam logic [7:0] CP_ENYE_UPPER = 8'hD1;
	localparam logic [7:0] CP_PRINT_LO   = 8'h20;
	localparam logic [7:0] CP_PRINT_HI   = 8'h7E;

	// Configuration register indexes.
	localparam logic [2:0] REG_DEBOUNCE = 3'd0;
	localparam logic [2:0] REG_DELAY    = 3'd1;
	localparam logic [2:0] REG_INTERVAL = 3'd2;
	localparam logic [2:0] REG_IDLE     = 3'd3;
	localparam logic [2:0] REG_SPECIAL_A = 3'd4;
	localparam logic [2:0] REG_SPECIAL_B = 3'd5;

	typedef struct packed {
		logic              bus_ok;
		logic [7:0]        scan_code;
		logic [TIME_W-1:0] time_ms;
	} poll_t;

	typedef struct packed {
		logic [3:0] key_class;
		logic [7:0] code_point;
		logic       is_repeat;
	} key_t;

	typedef struct packed {
		logic       mapped;
		logic [3:0] key_class;
		logic [7:0] code_point;
	} decode_t;

endpackage

/* sv/key_debounce_with_autorepeat.sv */
// Key debounce with autorepeat, top level. Depends on kdb_pkg, kdb_decode and the defines header.
// A transferred poll lands in the input register, and its key result, if any, is then offered
// from the result register. The state update is a single pass of compares and 64-bit adds.
// Throughput: one poll per cycle, as long as each result is taken when it is offered.
// Reset (arst_n low, asynchronous) clears the valid flags of both pipeline registers, the debounce
// state, and returns the configuration registers to their documented defaults.
`include "key_debounce_with_autorepeat_defines.svh"

module key_debounce_with_autorepeat (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port.
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	// Poll channel.
	input  logic                 poll_valid,
	output logic                 poll_stall,
	input  kdb_pkg::poll_t       poll_data,
	// Key result channel.
	output logic                 key_valid,
	input  logic                 key_stall,
	output kdb_pkg::key_t        key_data
);

	localparam int TW = kdb_pkg::TIME_W;

	// Configuration registers.
	logic [15:0] debounce_q;
	logic [15:0] delay_q;
	logic [15:0] interval_q;
	logic [7:0]  idle_q;
	logic [63:0] special_a_q;
	logic [23:0] special_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= 16'd20;
			delay_q     <= 16'd500;
			interval_q  <= 16'd125;
			idle_q      <= 8'd0;
			special_a_q <= '0;
			special_b_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				kdb_pkg::REG_DEBOUNCE:  debounce_q  <= cfg_data[15:0];
				kdb_pkg::REG_DELAY:     delay_q     <= cfg_data[15:0];
				kdb_pkg::REG_INTERVAL:  interval_q  <= cfg_data[15:0];
				kdb_pkg::REG_IDLE:      idle_q      <= cfg_data[7:0];
				kdb_pkg::REG_SPECIAL_A: special_a_q <= cfg_data;
				kdb_pkg::REG_SPECIAL_B: special_b_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Pipeline control. The result register frees up when it is empty or its transfer
	// completes; the input stage moves forward at the same time, so a poll can follow
	// in every cycle as long as each result is taken when it is offered.
	logic           valid_s1;
	kdb_pkg::poll_t poll_s1;
	logic           key_valid_q;
	kdb_pkg::key_t  key_data_q;
	logic           advance;
	logic           move_s1;

	assign advance    = !key_valid_q || !key_stall;
	assign move_s1    = valid_s1 && advance;
	assign poll_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!poll_stall) begin
			valid_s1 <= poll_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_valid && !poll_stall) begin
			poll_s1 <= poll_data;
		end
	end

	// Debounce and repeat state.
	logic [7:0]    accepted_q;
	logic [7:0]    candidate_q;
	logic [TW-1:0] cand_start_q;
	logic          armed_q;
	logic [3:0]    rep_class_q;
	logic [7:0]    rep_char_q;
	logic [TW-1:0] next_rep_q;

	kdb_pkg::decode_t dec;

	kdb_decode u_decode (
		.scan_code       (poll_s1.scan_code),
		.special_codes_a (special_a_q),
		.special_codes_b (special_b_q),
		.result          (dec)
	);

	// Time arithmetic on the registered poll. Schedules saturate at the largest time.
	logic [TW:0]   sum_delay;
	logic [TW:0]   sum_interval;
	logic [TW-1:0] sched_delay;
	logic [TW-1:0] sched_interval;
	logic [TW-1:0] elapsed;
	logic          debounced;
	logic          repeat_due;
	logic          repeatable;

	assign sum_delay      = {1'b0, poll_s1.time_ms} + {{(TW-15){1'b0}}, delay_q};
	assign sum_interval   = {1'b0, poll_s1.time_ms} + {{(TW-15){1'b0}}, interval_q};
	assign sched_delay    = sum_delay[TW] ? kdb_pkg::TIME_MAX : sum_delay[TW-1:0];
	assign sched_interval = sum_interval[TW] ? kdb_pkg::TIME_MAX : sum_interval[TW-1:0];
	assign elapsed        = poll_s1.time_ms - cand_start_q;

	// A candidate whose start lies in the future is never stable long enough.
	assign debounced  = (poll_s1.time_ms >= cand_start_q) &&
		((elapsed[TW-1:16] != '0) || (elapsed[15:0] >= debounce_q));
	assign repeat_due = armed_q && (poll_s1.time_ms >= next_rep_q);
	// Arrow keys and characters repeat; the command keys do not.
	assign repeatable = (dec.key_class == kdb_pkg::CLS_CHAR) ||
		(dec.key_class == kdb_pkg::CLS_UP) || (dec.key_class == kdb_pkg::CLS_DOWN) ||
		(dec.key_class == kdb_pkg::CLS_LEFT) || (dec.key_class == kdb_pkg::CLS_RIGHT);

	logic [7:0]    accepted_d;
	logic [7:0]    candidate_d;
	logic [TW-1:0] cand_start_d;
	logic          armed_d;
	logic [3:0]    rep_class_d;
	logic [7:0]    rep_char_d;
	logic [TW-1:0] next_rep_d;
	logic          emit;
	kdb_pkg::key_t result;

	always_comb begin
		accepted_d   = accepted_q;
		candidate_d  = candidate_q;
		cand_start_d = cand_start_q;
		armed_d      = armed_q;
		rep_class_d  = rep_class_q;
		rep_char_d   = rep_char_q;
		next_rep_d   = next_rep_q;
		emit         = 1'b0;
		result       = '0;
		if (!poll_s1.bus_ok) begin
			// An unreadable bus stops repeating and falls back to the accepted key.
			armed_d     = 1'b0;
			candidate_d = accepted_q;
		end else if (poll_s1.scan_code != candidate_q) begin
			// A new code restarts the debounce window.
			candidate_d  = poll_s1.scan_code;
			cand_start_d = poll_s1.time_ms;
		end else if (poll_s1.scan_code == accepted_q) begin
			// The accepted key is still held: fire a repeat when one is due.
			if (repeat_due) begin
				next_rep_d = sched_interval;
				emit       = 1'b1;
				result     = '{key_class: rep_class_q, code_point: rep_char_q, is_repeat: 1'b1};
			end
		end else if (debounced) begin
			// A stable new code becomes the accepted key.
			accepted_d = poll_s1.scan_code;
			armed_d    = 1'b0;
			if ((poll_s1.scan_code != idle_q) && dec.mapped) begin
				emit   = 1'b1;
				result = '{key_class: dec.key_class, code_point: dec.code_point, is_repeat: 1'b0};
				if (repeatable) begin
					armed_d     = 1'b1;
					rep_class_d = dec.key_class;
					rep_char_d  = dec.code_point;
					next_rep_d  = sched_delay;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q   <= '0;
			candidate_q  <= '0;
			cand_start_q <= '0;
			armed_q      <= 1'b0;
			rep_class_q  <= '0;
			rep_char_q   <= '0;
			next_rep_q   <= '0;
		end else if (move_s1) begin
			accepted_q   <= accepted_d;
			candidate_q  <= candidate_d;
			cand_start_q <= cand_start_d;
			armed_q      <= armed_d;
			rep_class_q  <= rep_class_d;
			rep_char_q   <= rep_char_d;
			next_rep_q   <= next_rep_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_q <= 1'b0;
		end else if (advance) begin
			key_valid_q <= move_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && emit) begin
			key_data_q <= result;
		end
	end

	assign key_valid = key_valid_q;
	assign key_data  = key_data_q;

	// A processed poll that yields a key shows it on the next cycle.
	`KDB_ASSERT_NEXT(a_emit_shows, move_s1 && emit, key_valid_q)
	// The input side holds off exactly when a waiting poll cannot move on.
	`KDB_ASSERT_IMPL(a_stall_when_stuck, valid_s1 && !advance, poll_stall)
	// Only repeatable classes are ever armed.
	`KDB_ASSERT_IMPL(a_armed_class, armed_q,
		(rep_class_q == kdb_pkg::CLS_CHAR) || (rep_class_q == kdb_pkg::CLS_UP) ||
		(rep_class_q == kdb_pkg::CLS_DOWN) || (rep_class_q == kdb_pkg::CLS_LEFT) ||
		(rep_class_q == kdb_pkg::CLS_RIGHT))
	// Non-character keys carry no character code.
	`KDB_ASSERT_IMPL(a_code_point_zero,
		key_valid_q && (key_data_q.key_class != kdb_pkg::CLS_CHAR),
		key_data_q.code_point == 8'h00)

endmodule

/* sv/kdb_decode.sv */
// Scancode decoder of the key debounce block: special keys, then printable ASCII.
// Depends on kdb_pkg.
module kdb_decode (
	input  logic [7:0]       scan_code,
	input  logic [63:0]      special_codes_a,
	input  logic [23:0]      special_codes_b,
	output kdb_pkg::decode_t result
);

	always_comb begin
		result = '0;
		if ((scan_code >= kdb_pkg::CP_PRINT_LO) && (scan_code <= kdb_pkg::CP_PRINT_HI)) begin
			result = '{mapped: 1'b1, key_class: kdb_pkg::CLS_CHAR, code_point: scan_code};
		end
		// Later tests override earlier ones: special_codes_a beats special_codes_b, lower bytes beat higher.
		if (special_codes_b[23:16] == scan_code) begin
			result = '{mapped: 1'b1, key_class: kdb_pkg::CLS_CHAR,
				code_point: kdb_pkg::CP_ENYE_UPPER};
		end
		if (special_codes_b[15:8] == scan_code) begin
			result = '{mapped: 1'b1, key_class: kdb_pkg::CLS_CHAR,
				code_point: kdb_pkg::CP_ENYE_LOWER};
		end
		if (special_codes_b[7:0] == scan_code) begin
			result = '{mapped: 1'b1, key_class: kdb_pkg::CLS_RIGHT, code_point: 8'h00};
		end
		for (int i = 7; i >= 0; i--) begin
			if (special_codes_a[8*i +: 8] == scan_code) begin
				result = '{mapped: 1'b1, key_class: 4'(i), code_point: 8'h00};
			end
		end
	end

endmodule
